/* hdl/usrr_pkg.sv */
// Shared types, codes and descriptor contents for the setup request responder.
package usrr_pkg;

	localparam int IDX_W  = 6;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 4;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_ACK   = 2'd1,
		KIND_UNSUP = 2'd2
	} resp_kind_t;

	typedef enum logic [1:0] {
		REG_VENDOR_ID  = 2'd0,
		REG_PRODUCT_ID = 2'd1,
		REG_MAX_LUN    = 2'd2,
		REG_NONE       = 2'd3
	} reg_idx_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} seq_state_t;

	typedef enum logic [2:0] {
		MODE_ROM,
		MODE_DEVICE,
		MODE_SERIAL_SHORT,
		MODE_ACK,
		MODE_LUN,
		MODE_UNSUP
	} req_mode_t;

	typedef enum logic [2:0] {
		SRC_ROM,
		SRC_VID_LO,
		SRC_VID_HI,
		SRC_PID_LO,
		SRC_PID_HI,
		SRC_SER_LEN,
		SRC_LUN,
		SRC_ZERO
	} byte_src_t;

	localparam logic [7:0]  CODE_SET_ADDRESS = 8'h05;
	localparam logic [7:0]  CODE_GET_DESC    = 8'h06;
	localparam logic [7:0]  CODE_SET_CONFIG  = 8'h09;
	localparam logic [7:0]  CODE_MAX_LUN     = 8'hFE;
	localparam logic [7:0]  TYPE_MAX_LUN     = 8'hA1;

	localparam logic [15:0] DESC_DEVICE  = 16'h0100;
	localparam logic [15:0] DESC_CONFIG  = 16'h0200;
	localparam logic [15:0] DESC_LANG    = 16'h0300;
	localparam logic [15:0] DESC_PRODUCT = 16'h0302;
	localparam logic [15:0] DESC_SERIAL  = 16'h0303;

	localparam logic [7:0] OFS_DEVICE  = 8'd0;
	localparam logic [7:0] OFS_CONFIG  = 8'd18;
	localparam logic [7:0] OFS_LANG    = 8'd50;
	localparam logic [7:0] OFS_PRODUCT = 8'd54;
	localparam logic [7:0] OFS_SERIAL  = 8'd78;

	localparam logic [15:0] VENDOR_ID_RST  = 16'h0930;
	localparam logic [15:0] PRODUCT_ID_RST = 16'h6544;
	localparam logic [7:0]  SERIAL_SHORT_LEN = 8'h02;
	localparam logic [7:0]  CONFIGURED_BIT = 8'h80;

	localparam logic [7:0] DESC_BYTES [128] = '{
		8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40,
		8'h30, 8'h09, 8'h44, 8'h65, 8'h00, 8'h01, 8'h01, 8'h02, 8'h03, 8'h01,
		8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'h32,
		8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'h08, 8'h06, 8'h50, 8'h00,
		8'h07, 8'h05, 8'h81, 8'h02, 8'h00, 8'h02, 8'hFF,
		8'h07, 8'h05, 8'h02, 8'h02, 8'h00, 8'h02, 8'hFF,
		8'h04, 8'h03, 8'h09, 8'h04,
		8'h18, 8'h03, 8'h49, 8'h00, 8'h20, 8'h00, 8'h6C, 8'h00, 8'h6F, 8'h00,
		8'h76, 8'h00, 8'h65, 8'h00, 8'h20, 8'h00, 8'h53, 8'h00, 8'h4E, 8'h00,
		8'h53, 8'h00, 8'h44, 8'h00,
		8'h32, 8'h03,
		8'h30, 8'h00, 8'h30, 8'h00, 8'h31, 8'h00, 8'h30, 8'h00,
		8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00,
		8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00,
		8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00,
		8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00,
		8'h30, 8'h00, 8'h32, 8'h00, 8'h30, 8'h00, 8'h35, 8'h00
	};

	function automatic logic [7:0] desc_byte(input logic [7:0] idx);
		logic [7:0] b;
		b = idx[7] ? 8'h00 : DESC_BYTES[idx[6:0]];
		return b;
	endfunction

endpackage

/* hdl/usrr_req_if.sv */
// Setup request channel: valid/ready with the setup packet fields.
interface usrr_req_if;
	logic        valid;
	logic        ready;
	logic [7:0]  request_type;
	logic [7:0]  request_code;
	logic [15:0] request_value;
	logic [15:0] request_length;

	modport source (
		output valid, request_type, request_code, request_value, request_length,
		input  ready
	);
	modport sink (
		input  valid, request_type, request_code, request_value, request_length,
		output ready
	);
endinterface

/* hdl/usrr_rsp_if.sv */
// Response channel: valid/ready with one response byte or status per transfer.
interface usrr_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] response_kind;
	logic [7:0] data_byte;
	logic       last_item;
	logic [7:0] address_value;

	modport source (
		output valid, response_kind, data_byte, last_item, address_value,
		input  ready
	);
	modport sink (
		input  valid, response_kind, data_byte, last_item, address_value,
		output ready
	);
endinterface

/* hdl/usrr_rom.sv */
// Descriptor store: synchronous-read ROM, read data held while not enabled.
module usrr_rom #(
	parameter int DESC_STORE_BYTES = 128
) (
	input  logic                                clk,
	input  logic                                rd_en,
	input  logic [$clog2(DESC_STORE_BYTES)-1:0] rd_addr,
	output logic [7:0]                          rd_data
);

	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= usrr_pkg::desc_byte(8'(rd_addr));
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/usb_setup_request_responder_top.sv */
// Top level of the USB setup request responder: decode, byte sequencer, output stage.
//
//  channel  dir  handshake        contents
//  req      in   valid/ready      request_type, request_code, request_value, request_length
//  rsp      out  valid/ready      response_kind, data_byte, last_item, address_value
//  apb      in   psel/penable     vendor_id, product_id, max_lun (write and read)
//
// A request is taken only when the sequencer is idle; it then issues one descriptor
// ROM read per cycle while the output does not stall, for 1 to 50 results per request.
// The first transfer follows the taken request through issue, the ROM read stage
// and the output register.
// A stalled output holds the ROM read stage, which in turn stops issue.
// arst_n resets the sequencer, valid bits, address register and config registers.
module usb_setup_request_responder_top #(
	parameter int DESC_STORE_BYTES = 128
) (
	input  logic                         clk,
	input  logic                         arst_n,
	usrr_req_if.sink                     req,
	usrr_rsp_if.source                   rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [usrr_pkg::ADDR_W-1:0]  paddr,
	input  logic [usrr_pkg::DATA_W-1:0]  pwdata,
	output logic [usrr_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);

	localparam int AW = $clog2(DESC_STORE_BYTES);

	// config registers
	logic [15:0] vendor_id_q;
	logic [15:0] product_id_q;
	logic [3:0]  max_lun_q;
	logic        cfg_wr;
	usrr_pkg::reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = usrr_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vendor_id_q  <= usrr_pkg::VENDOR_ID_RST;
			product_id_q <= usrr_pkg::PRODUCT_ID_RST;
			max_lun_q    <= 4'd0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				usrr_pkg::REG_VENDOR_ID:  vendor_id_q  <= pwdata[15:0];
				usrr_pkg::REG_PRODUCT_ID: product_id_q <= pwdata[15:0];
				usrr_pkg::REG_MAX_LUN:    max_lun_q    <= pwdata[3:0];
				usrr_pkg::REG_NONE:       ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			usrr_pkg::REG_VENDOR_ID:  prdata = {16'd0, vendor_id_q};
			usrr_pkg::REG_PRODUCT_ID: prdata = {16'd0, product_id_q};
			usrr_pkg::REG_MAX_LUN:    prdata = {28'd0, max_lun_q};
			usrr_pkg::REG_NONE:       prdata = '0;
		endcase
	end

	// sequencer
	usrr_pkg::seq_state_t state_q, state_nxt;
	usrr_pkg::req_mode_t  mode_q, mode_dec;
	logic [7:0]           ofs_q, ofs_dec;
	usrr_pkg::idx_t       idx_q, last_idx_q, last_idx_dec;
	logic [7:0]           address_q;
	logic                 req_acc;
	logic                 issue_en;
	logic                 issue_last;
	logic                 adv;
	logic                 v_s1;

	assign req_acc    = req.valid && req.ready;
	assign issue_last = idx_q == last_idx_q;

	always_comb begin
		mode_dec     = usrr_pkg::MODE_UNSUP;
		ofs_dec      = usrr_pkg::OFS_DEVICE;
		last_idx_dec = '0;
		priority if (req.request_code == usrr_pkg::CODE_GET_DESC) begin
			unique case (req.request_value)
				usrr_pkg::DESC_DEVICE: begin
					mode_dec     = usrr_pkg::MODE_DEVICE;
					ofs_dec      = usrr_pkg::OFS_DEVICE;
					last_idx_dec = usrr_pkg::IDX_W'(17);
				end
				usrr_pkg::DESC_CONFIG: begin
					mode_dec     = usrr_pkg::MODE_ROM;
					ofs_dec      = usrr_pkg::OFS_CONFIG;
					last_idx_dec = (req.request_length == 16'd9) ?
						usrr_pkg::IDX_W'(8) : usrr_pkg::IDX_W'(31);
				end
				usrr_pkg::DESC_LANG: begin
					mode_dec     = usrr_pkg::MODE_ROM;
					ofs_dec      = usrr_pkg::OFS_LANG;
					last_idx_dec = (req.request_length == 16'd2) ?
						usrr_pkg::IDX_W'(1) : usrr_pkg::IDX_W'(3);
				end
				usrr_pkg::DESC_PRODUCT: begin
					mode_dec     = usrr_pkg::MODE_ROM;
					ofs_dec      = usrr_pkg::OFS_PRODUCT;
					last_idx_dec = usrr_pkg::IDX_W'(23);
				end
				usrr_pkg::DESC_SERIAL: begin
					ofs_dec = usrr_pkg::OFS_SERIAL;
					if (req.request_length == 16'd2) begin
						mode_dec     = usrr_pkg::MODE_SERIAL_SHORT;
						last_idx_dec = usrr_pkg::IDX_W'(1);
					end else begin
						mode_dec     = usrr_pkg::MODE_ROM;
						last_idx_dec = usrr_pkg::IDX_W'(49);
					end
				end
				default: mode_dec = usrr_pkg::MODE_UNSUP;
			endcase
		end else if (req.request_code == usrr_pkg::CODE_SET_ADDRESS ||
		             req.request_code == usrr_pkg::CODE_SET_CONFIG) begin
			mode_dec = usrr_pkg::MODE_ACK;
		end else if (req.request_code == usrr_pkg::CODE_MAX_LUN &&
		             req.request_type == usrr_pkg::TYPE_MAX_LUN) begin
			mode_dec = usrr_pkg::MODE_LUN;
		end else begin
			mode_dec = usrr_pkg::MODE_UNSUP;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			usrr_pkg::ST_IDLE: if (req_acc) state_nxt = usrr_pkg::ST_RUN;
			usrr_pkg::ST_RUN:  if (issue_en && issue_last) state_nxt = usrr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		issue_en  = 1'b0;
		unique case (state_q)
			usrr_pkg::ST_IDLE: req.ready = 1'b1;
			usrr_pkg::ST_RUN:  issue_en  = !v_s1 || adv;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= usrr_pkg::ST_IDLE;
			address_q <= 8'd0;
		end else begin
			state_q <= state_nxt;
			if (req_acc && req.request_code == usrr_pkg::CODE_SET_ADDRESS) begin
				address_q <= req.request_value[7:0];
			end else if (req_acc && req.request_code == usrr_pkg::CODE_SET_CONFIG) begin
				address_q <= address_q | usrr_pkg::CONFIGURED_BIT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			mode_q     <= mode_dec;
			ofs_q      <= ofs_dec;
			last_idx_q <= last_idx_dec;
			idx_q      <= '0;
		end else if (issue_en) begin
			idx_q <= idx_q + usrr_pkg::IDX_W'(1);
		end
	end

	// byte source for the current index
	usrr_pkg::byte_src_t  src_iss;
	usrr_pkg::resp_kind_t kind_iss;
	logic [AW-1:0]        rom_addr;

	assign rom_addr = AW'(ofs_q) + AW'(idx_q);

	always_comb begin
		src_iss  = usrr_pkg::SRC_ROM;
		kind_iss = usrr_pkg::KIND_DATA;
		unique case (mode_q)
			usrr_pkg::MODE_ROM: src_iss = usrr_pkg::SRC_ROM;
			usrr_pkg::MODE_DEVICE: begin
				unique case (idx_q)
					usrr_pkg::IDX_W'(8):  src_iss = usrr_pkg::SRC_VID_LO;
					usrr_pkg::IDX_W'(9):  src_iss = usrr_pkg::SRC_VID_HI;
					usrr_pkg::IDX_W'(10): src_iss = usrr_pkg::SRC_PID_LO;
					usrr_pkg::IDX_W'(11): src_iss = usrr_pkg::SRC_PID_HI;
					default:              src_iss = usrr_pkg::SRC_ROM;
				endcase
			end
			usrr_pkg::MODE_SERIAL_SHORT:
				src_iss = (idx_q == '0) ? usrr_pkg::SRC_SER_LEN : usrr_pkg::SRC_ROM;
			usrr_pkg::MODE_ACK: begin
				src_iss  = usrr_pkg::SRC_ZERO;
				kind_iss = usrr_pkg::KIND_ACK;
			end
			usrr_pkg::MODE_LUN: src_iss = usrr_pkg::SRC_LUN;
			default: begin
				src_iss  = usrr_pkg::SRC_ZERO;
				kind_iss = usrr_pkg::KIND_UNSUP;
			end
		endcase
	end

	// ROM read stage
	logic [7:0]           rom_data;
	usrr_pkg::byte_src_t  src_s1;
	usrr_pkg::resp_kind_t kind_s1;
	logic                 last_s1;
	logic [7:0]           addr_s1;
	logic [7:0]           byte_s1;

	usrr_rom #(
		.DESC_STORE_BYTES(DESC_STORE_BYTES)
	) u_rom (
		.clk     (clk),
		.rd_en   (issue_en),
		.rd_addr (rom_addr),
		.rd_data (rom_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (issue_en) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue_en) begin
			src_s1  <= src_iss;
			kind_s1 <= kind_iss;
			last_s1 <= issue_last;
			addr_s1 <= address_q;
		end
	end

	always_comb begin
		unique case (src_s1)
			usrr_pkg::SRC_ROM:     byte_s1 = rom_data;
			usrr_pkg::SRC_VID_LO:  byte_s1 = vendor_id_q[7:0];
			usrr_pkg::SRC_VID_HI:  byte_s1 = vendor_id_q[15:8];
			usrr_pkg::SRC_PID_LO:  byte_s1 = product_id_q[7:0];
			usrr_pkg::SRC_PID_HI:  byte_s1 = product_id_q[15:8];
			usrr_pkg::SRC_SER_LEN: byte_s1 = usrr_pkg::SERIAL_SHORT_LEN;
			usrr_pkg::SRC_LUN:     byte_s1 = {4'd0, max_lun_q};
			usrr_pkg::SRC_ZERO:    byte_s1 = 8'd0;
		endcase
	end

	// output register
	logic                 out_valid_q;
	usrr_pkg::resp_kind_t out_kind_q;
	logic [7:0]           out_data_q;
	logic                 out_last_q;
	logic [7:0]           out_addr_q;

	assign adv = v_s1 && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_kind_q <= kind_s1;
			out_data_q <= byte_s1;
			out_last_q <= last_s1;
			out_addr_q <= addr_s1;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.response_kind = out_kind_q;
	assign rsp.data_byte     = out_data_q;
	assign rsp.last_item     = out_last_q;
	assign rsp.address_value = out_addr_q;

	a_last_issue_idles: assert property (@(posedge clk) disable iff (!arst_n)
		issue_en && issue_last |=> state_q == usrr_pkg::ST_IDLE)
		else $error("sequencer still running after last issue");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(rom_data))
		else $error("held ROM read stage changed");

	a_set_address: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req.request_code == usrr_pkg::CODE_SET_ADDRESS
		|=> address_q == $past(req.request_value[7:0]))
		else $error("address register not updated");

	a_nondata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.response_kind != usrr_pkg::KIND_DATA |-> rsp.data_byte == 8'd0)
		else $error("status transfer carries data");

endmodule

/* tb/usb_setup_request_responder_top_tb.sv */
// Self-checking testbench for the setup request responder: random setups, APB config, scoreboard.
module usb_setup_request_responder_top_tb;

	typedef struct {
		logic [7:0]  rtype;
		logic [7:0]  code;
		logic [15:0] value;
		logic [15:0] length;
	} setup_t;

	typedef struct {
		usrr_pkg::resp_kind_t kind;
		logic [7:0] data;
		logic       last;
		logic [7:0] addr;
	} answer_t;

	localparam logic [7:0] DESC_IMAGE [128] = '{
		8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40,
		8'h30, 8'h09, 8'h44, 8'h65, 8'h00, 8'h01, 8'h01, 8'h02, 8'h03, 8'h01,
		8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'h32,
		8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'h08, 8'h06, 8'h50, 8'h00,
		8'h07, 8'h05, 8'h81, 8'h02, 8'h00, 8'h02, 8'hFF,
		8'h07, 8'h05, 8'h02, 8'h02, 8'h00, 8'h02, 8'hFF,
		8'h04, 8'h03, 8'h09, 8'h04,
		8'h18, 8'h03, 8'h49, 8'h00, 8'h20, 8'h00, 8'h6C, 8'h00, 8'h6F, 8'h00,
		8'h76, 8'h00, 8'h65, 8'h00, 8'h20, 8'h00, 8'h53, 8'h00, 8'h4E, 8'h00,
		8'h53, 8'h00, 8'h44, 8'h00,
		8'h32, 8'h03,
		8'h30, 8'h00, 8'h30, 8'h00, 8'h31, 8'h00, 8'h30, 8'h00,
		8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00,
		8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00,
		8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00,
		8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00,
		8'h30, 8'h00, 8'h32, 8'h00, 8'h30, 8'h00, 8'h35, 8'h00
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel;
	logic penable;
	logic pwrite;
	logic [usrr_pkg::ADDR_W-1:0] paddr;
	logic [usrr_pkg::DATA_W-1:0] pwdata;
	logic [usrr_pkg::DATA_W-1:0] prdata;
	logic pready;

	usrr_req_if req_bus ();
	usrr_rsp_if rsp_bus ();

	usb_setup_request_responder_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_bus),
		.rsp     (rsp_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #2 clk = ~clk;

	setup_t     setup_q [$];
	answer_t    answer_q [$];
	logic [15:0] vendor_reg = usrr_pkg::VENDOR_ID_RST;
	logic [15:0] product_reg = usrr_pkg::PRODUCT_ID_RST;
	logic [3:0]  lun_reg = 4'd0;
	logic [7:0]  addr_reg = 8'd0;
	bit failed = 1'b0;
	int sent_count = 0;
	int taken_count = 0;
	int req_gap_max = 14;
	int rsp_gap_max = 14;
	int hold_requests = 0;
	logic req_taken = 1'b0;
	logic rsp_taken = 1'b0;

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			failed = 1'b1;
		end
	endfunction

	function automatic void push_answer(usrr_pkg::resp_kind_t kind, logic [7:0] data,
			logic last);
		answer_t a;
		a.kind = kind;
		a.data = data;
		a.last = last;
		a.addr = addr_reg;
		answer_q.push_back(a);
	endfunction

	// Expected transfers for one accepted setup packet.
	function automatic void answer_setup(setup_t s);
		int         n;
		int         i;
		logic [7:0] ofs;
		logic       ser_short;
		logic [7:0] b;
		n = 0;
		ofs = usrr_pkg::OFS_DEVICE;
		ser_short = 1'b0;
		if (s.code == usrr_pkg::CODE_GET_DESC) begin
			case (s.value)
				usrr_pkg::DESC_DEVICE: begin
					ofs = usrr_pkg::OFS_DEVICE;
					n = 18;
				end
				usrr_pkg::DESC_CONFIG: begin
					ofs = usrr_pkg::OFS_CONFIG;
					n = (s.length == 16'd9) ? 9 : 32;
				end
				usrr_pkg::DESC_LANG: begin
					ofs = usrr_pkg::OFS_LANG;
					n = (s.length == 16'd2) ? 2 : 4;
				end
				usrr_pkg::DESC_PRODUCT: begin
					ofs = usrr_pkg::OFS_PRODUCT;
					n = 24;
				end
				usrr_pkg::DESC_SERIAL: begin
					ofs = usrr_pkg::OFS_SERIAL;
					ser_short = (s.length == 16'd2);
					n = ser_short ? 2 : 50;
				end
				default: n = 0;
			endcase
			if (n == 0)
				push_answer(usrr_pkg::KIND_UNSUP, 8'd0, 1'b1);
			for (i = 0; i < n; i++) begin
				b = DESC_IMAGE[ofs + i];
				if (ofs == usrr_pkg::OFS_DEVICE) begin
					case (i)
						8: b = vendor_reg[7:0];
						9: b = vendor_reg[15:8];
						10: b = product_reg[7:0];
						11: b = product_reg[15:8];
						default: ;
					endcase
				end
				if (ser_short && i == 0)
					b = usrr_pkg::SERIAL_SHORT_LEN;
				push_answer(usrr_pkg::KIND_DATA, b, i == n - 1);
			end
		end else if (s.code == usrr_pkg::CODE_SET_ADDRESS) begin
			addr_reg = s.value[7:0];
			push_answer(usrr_pkg::KIND_ACK, 8'd0, 1'b1);
		end else if (s.code == usrr_pkg::CODE_SET_CONFIG) begin
			addr_reg = addr_reg | usrr_pkg::CONFIGURED_BIT;
			push_answer(usrr_pkg::KIND_ACK, 8'd0, 1'b1);
		end else if (s.code == usrr_pkg::CODE_MAX_LUN && s.rtype == usrr_pkg::TYPE_MAX_LUN) begin
			push_answer(usrr_pkg::KIND_DATA, {4'd0, lun_reg}, 1'b1);
		end else begin
			push_answer(usrr_pkg::KIND_UNSUP, 8'd0, 1'b1);
		end
	endfunction

	// Acceptance, prediction and scoreboard.
	always @(posedge clk) begin
		answer_t want;
		setup_t  s;
		req_taken <= arst_n && req_bus.valid && req_bus.ready;
		rsp_taken <= arst_n && rsp_bus.valid && rsp_bus.ready;
		if (arst_n && req_bus.valid && req_bus.ready) begin
			s.rtype = req_bus.request_type;
			s.code = req_bus.request_code;
			s.value = req_bus.request_value;
			s.length = req_bus.request_length;
			answer_setup(s);
			taken_count++;
		end
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (answer_q.size() == 0) begin
				$error("unexpected transfer: kind %0d data %h last %b", rsp_bus.response_kind,
					rsp_bus.data_byte, rsp_bus.last_item);
				failed = 1'b1;
			end else begin
				want = answer_q.pop_front();
				check_field("response_kind", want.kind, rsp_bus.response_kind);
				check_field("data_byte", want.data, rsp_bus.data_byte);
				check_field("last_item", want.last, rsp_bus.last_item);
				check_field("address_value", want.addr, rsp_bus.address_value);
			end
		end
	end

	// Request driver.
	int     req_gap_left = 0;
	setup_t next_setup;
	always @(negedge clk) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
		end else if (!req_bus.valid || req_taken) begin
			if (setup_q.size() == 0 || req_gap_left > 0) begin
				if (req_gap_left > 0)
					req_gap_left--;
				req_bus.valid <= 1'b0;
			end else begin
				next_setup = setup_q.pop_front();
				req_bus.request_type <= next_setup.rtype;
				req_bus.request_code <= next_setup.code;
				req_bus.request_value <= next_setup.value;
				req_bus.request_length <= next_setup.length;
				req_bus.valid <= 1'b1;
				req_gap_left = $urandom_range(0, req_gap_max);
			end
		end
	end

	// Response receiver: per-transfer stall plus an occasional long hold-off.
	int rsp_stall_left = 0;
	int hold_left = 0;
	int hold_served = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else begin
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = 400;
			end
			if (rsp_taken)
				rsp_stall_left = $urandom_range(0, rsp_gap_max);
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else if (rsp_stall_left > 0) begin
				rsp_stall_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	task automatic reg_write(usrr_pkg::reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			usrr_pkg::REG_VENDOR_ID: vendor_reg = val[15:0];
			usrr_pkg::REG_PRODUCT_ID: product_reg = val[15:0];
			usrr_pkg::REG_MAX_LUN: lun_reg = val[3:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reg_read(usrr_pkg::reg_idx_t idx);
		logic [31:0] want;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			usrr_pkg::REG_VENDOR_ID: want = {16'd0, vendor_reg};
			usrr_pkg::REG_PRODUCT_ID: want = {16'd0, product_reg};
			default: want = {28'd0, lun_reg};
		endcase
		check_field("prdata", want, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(logic [15:0] vid, logic [15:0] pid, logic [3:0] lun);
		reg_write(usrr_pkg::REG_VENDOR_ID, {16'd0, vid});
		reg_write(usrr_pkg::REG_PRODUCT_ID, {16'd0, pid});
		reg_write(usrr_pkg::REG_MAX_LUN, {28'd0, lun});
		reg_read(usrr_pkg::REG_VENDOR_ID);
		reg_read(usrr_pkg::REG_PRODUCT_ID);
		reg_read(usrr_pkg::REG_MAX_LUN);
	endtask

	task automatic set_random_config();
		set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			4'($urandom_range(0, 15)));
	endtask

	task automatic add_setup(logic [7:0] rtype, logic [7:0] code, logic [15:0] value,
			logic [15:0] length);
		setup_t s;
		s.rtype = rtype;
		s.code = code;
		s.value = value;
		s.length = length;
		setup_q.push_back(s);
		sent_count++;
	endtask

	// Mostly well-formed requests with random content, the rest noise.
	task automatic add_random_setup();
		int     pick;
		setup_t s;
		pick = $urandom_range(0, 99);
		s.rtype = 8'($urandom_range(0, 255));
		s.code = 8'($urandom_range(0, 255));
		s.value = 16'($urandom_range(0, 65535));
		s.length = 16'($urandom_range(0, 65535));
		if (pick < 55) begin
			s.code = usrr_pkg::CODE_GET_DESC;
			case ($urandom_range(0, 6))
				0: s.value = usrr_pkg::DESC_DEVICE;
				1: s.value = usrr_pkg::DESC_CONFIG;
				2: s.value = usrr_pkg::DESC_LANG;
				3: s.value = usrr_pkg::DESC_PRODUCT;
				4: s.value = usrr_pkg::DESC_SERIAL;
				5: s.value = usrr_pkg::DESC_SERIAL + 16'($urandom_range(1, 252));
				default: ;
			endcase
			if ($urandom_range(0, 1))
				s.length = $urandom_range(0, 1) ? 16'd9 : 16'd2;
		end else if (pick < 67) begin
			s.code = usrr_pkg::CODE_SET_ADDRESS;
		end else if (pick < 75) begin
			s.code = usrr_pkg::CODE_SET_CONFIG;
		end else if (pick < 85) begin
			s.code = usrr_pkg::CODE_MAX_LUN;
			if ($urandom_range(0, 3) != 0)
				s.rtype = usrr_pkg::TYPE_MAX_LUN;
		end
		add_setup(s.rtype, s.code, s.value, s.length);
	endtask

	task automatic wait_idle();
		while (taken_count != sent_count || answer_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		#3000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		req_bus.valid = 1'b0;
		req_bus.request_type = 8'd0;
		req_bus.request_code = 8'd0;
		req_bus.request_value = 16'd0;
		req_bus.request_length = 16'd0;
		rsp_bus.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		reg_read(usrr_pkg::REG_VENDOR_ID);
		reg_read(usrr_pkg::REG_PRODUCT_ID);
		reg_read(usrr_pkg::REG_MAX_LUN);

		// directed: every descriptor and its short/full form, codes, field extremes
		add_setup(8'h80, usrr_pkg::CODE_GET_DESC, usrr_pkg::DESC_DEVICE, 16'h0012);
		add_setup(8'h80, usrr_pkg::CODE_GET_DESC, usrr_pkg::DESC_CONFIG, 16'd9);
		add_setup(8'h80, usrr_pkg::CODE_GET_DESC, usrr_pkg::DESC_CONFIG, 16'hFFFF);
		add_setup(8'h80, usrr_pkg::CODE_GET_DESC, usrr_pkg::DESC_CONFIG, 16'd0);
		add_setup(8'h80, usrr_pkg::CODE_GET_DESC, usrr_pkg::DESC_LANG, 16'd2);
		add_setup(8'h80, usrr_pkg::CODE_GET_DESC, usrr_pkg::DESC_LANG, 16'hFFFF);
		add_setup(8'h80, usrr_pkg::CODE_GET_DESC, usrr_pkg::DESC_PRODUCT, 16'h00FF);
		add_setup(8'h80, usrr_pkg::CODE_GET_DESC, usrr_pkg::DESC_SERIAL, 16'd2);
		add_setup(8'h80, usrr_pkg::CODE_GET_DESC, usrr_pkg::DESC_SERIAL, 16'hFFFF);
		add_setup(8'h80, usrr_pkg::CODE_GET_DESC, usrr_pkg::DESC_SERIAL, 16'd3);
		add_setup(8'h80, usrr_pkg::CODE_GET_DESC, usrr_pkg::DESC_LANG + 16'd1, 16'h00FF);
		add_setup(8'hFF, usrr_pkg::CODE_GET_DESC, 16'hFFFF, 16'hFFFF);
		add_setup(8'h00, usrr_pkg::CODE_GET_DESC, 16'h0000, 16'h0000);
		add_setup(8'h00, usrr_pkg::CODE_GET_DESC, usrr_pkg::DESC_DEVICE, 16'd0);
		add_setup(8'h00, usrr_pkg::CODE_SET_ADDRESS, 16'hFFFF, 16'd0);
		add_setup(8'h00, usrr_pkg::CODE_SET_ADDRESS, 16'h0000, 16'hFFFF);
		add_setup(8'hFF, usrr_pkg::CODE_SET_ADDRESS, 16'hAA55, 16'd0);
		add_setup(8'h00, usrr_pkg::CODE_SET_CONFIG, 16'h0000, 16'd0);
		add_setup(8'hFF, usrr_pkg::CODE_SET_CONFIG, 16'hFFFF, 16'hFFFF);
		add_setup(usrr_pkg::TYPE_MAX_LUN, usrr_pkg::CODE_MAX_LUN, 16'd0, 16'd1);
		add_setup(8'h21, usrr_pkg::CODE_MAX_LUN, 16'd0, 16'd1);
		add_setup(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
		add_setup(8'h00, 8'h00, 16'h0000, 16'h0000);
		add_setup(8'h00, usrr_pkg::CODE_SET_ADDRESS, 16'h007F, 16'd0);
		wait_idle();

		set_config(16'hFFFF, 16'h0000, 4'hF);
		reg_write(usrr_pkg::REG_NONE, 32'hFFFF_FFFF);
		add_setup(8'h80, usrr_pkg::CODE_GET_DESC, usrr_pkg::DESC_DEVICE, 16'h0040);
		add_setup(usrr_pkg::TYPE_MAX_LUN, usrr_pkg::CODE_MAX_LUN, 16'hFFFF, 16'hFFFF);
		wait_idle();

		set_random_config();
		repeat (40) add_random_setup();
		wait_idle();

		req_gap_max = 0;
		rsp_gap_max = 0;
		set_random_config();
		repeat (30) add_random_setup();
		wait_idle();

		// receiver holds off while the sender keeps pushing
		rsp_gap_max = 3;
		set_config(16'h0000, 16'hFFFF, 4'h0);
		hold_requests++;
		repeat (30) add_random_setup();
		wait_idle();

		req_gap_max = 14;
		rsp_gap_max = 0;
		set_random_config();
		repeat (25) add_random_setup();
		wait_idle();
		repeat (40) @(negedge clk);

		if (!failed)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
